FILE: sv/mtg_pkg.sv
// Package for the multichannel taus88 generator: payload structs, command codes,
// channel count and the three-component Tausworthe recurrence.
// No dependencies.
`default_nettype none

package mtg_pkg;

  localparam int unsigned CHANNELS = 8;
  localparam int unsigned CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [31:0] WORD_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    CMD_STEP  = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_SCALE = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  channel;
    logic [31:0] seed_first;
    logic [31:0] seed_second;
    logic [31:0] seed_third;
    logic [31:0] range_low;
    logic [31:0] range_high;
  } in_t;

  typedef struct packed {
    logic [31:0] value;
    logic        error;
  } out_t;

  // Decoded command as it sits in the queue between front and back.
  typedef struct packed {
    cmd_e              op;
    logic              exists;
    logic              err;
    logic [CH_W-1:0]   chan;
    logic [31:0]       seed_first;
    logic [31:0]       seed_second;
    logic [31:0]       seed_third;
    logic [31:0]       range_low;
    logic [31:0]       range_high;
  } op_t;

  typedef struct packed {
    logic [31:0] c1;
    logic [31:0] c2;
    logic [31:0] c3;
  } comps_t;

  function automatic comps_t taus_next(input comps_t cur);
    comps_t nxt;
    logic [31:0] fb1, fb2, fb3;
    fb1 = ((cur.c1 << 13) ^ cur.c1) >> 19;
    fb2 = ((cur.c2 << 2) ^ cur.c2) >> 25;
    fb3 = ((cur.c3 << 3) ^ cur.c3) >> 11;
    nxt.c1 = ((cur.c1 & 32'hFFFF_FFFE) << 12) ^ fb1;
    nxt.c2 = ((cur.c2 & 32'hFFFF_FFF8) << 4) ^ fb2;
    nxt.c3 = ((cur.c3 & 32'hFFFF_FFF0) << 17) ^ fb3;
    return nxt;
  endfunction

endpackage

`default_nettype wire

FILE: sv/multichannel_taus88_generator.sv
// An accepted item passes the queue, the execute stage, the scale stage register
// and the result register before it shows on result_o. Throughput: one item per
// cycle while results are popped, set by the single update of the channel state
// bank in the execute stage. Reset: channel words and last outputs clear to zero,
// the queue empties. Depends on mtg_pkg, mtg_front, mtg_back.
`default_nettype none

module multichannel_taus88_generator (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire mtg_pkg::in_t  item_i,
  input  wire logic          push,
  output logic               full,
  output mtg_pkg::out_t      result_o,
  output logic               empty,
  input  wire logic          pop
);
  import mtg_pkg::*;

  logic q_valid, q_pop;
  op_t  q_head;

  mtg_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item_i),
    .push      (push),
    .full      (full),
    .q_valid_o (q_valid),
    .q_head_o  (q_head),
    .q_pop_i   (q_pop)
  );

  mtg_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_head_i  (q_head),
    .q_pop_o   (q_pop),
    .result_o  (result_o),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

`default_nettype wire

FILE: sv/mtg_front.sv
// Front end: takes items, decodes the command and channel, and holds them in a
// two-beat queue for the back end. Depends on mtg_pkg.
`default_nettype none

module mtg_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire mtg_pkg::in_t item_i,
  input  wire logic         push,
  output logic              full,
  output logic              q_valid_o,
  output mtg_pkg::op_t      q_head_o,
  input  wire logic         q_pop_i
);
  import mtg_pkg::*;

  op_t        slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;
  op_t        dec;

  always_comb begin
    dec.op          = cmd_e'(item_i.cmd);
    dec.exists      = (32'(item_i.channel) < 32'(CHANNELS));
    dec.chan        = CH_W'(item_i.channel);
    dec.err         = (dec.op == CMD_READ) && (!dec.exists || item_i.channel == 3'd0);
    dec.seed_first  = item_i.seed_first;
    dec.seed_second = item_i.seed_second;
    dec.seed_third  = item_i.seed_third;
    dec.range_low   = item_i.range_low;
    dec.range_high  = item_i.range_high;
  end

  assign full      = (cnt_q == 2'd2);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_head_o  = slot_q[rd_ptr_q];
  assign do_push   = push && !full;
  assign do_pop    = q_pop_i && q_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= dec;
    end
  end

endmodule

`default_nettype wire

FILE: sv/mtg_back.sv
// Back end: per-channel generator state, execute stage (advance, load, read,
// range multiply), scale stage and the result register. Depends on mtg_pkg.
`default_nettype none

module mtg_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  input  wire mtg_pkg::op_t  q_head_i,
  output logic               q_pop_o,
  output mtg_pkg::out_t      result_o,
  output logic               empty,
  input  wire logic          pop
);
  import mtg_pkg::*;

  logic [31:0] c1_q   [CHANNELS];
  logic [31:0] c2_q   [CHANNELS];
  logic [31:0] c3_q   [CHANNELS];
  logic [31:0] last_q [CHANNELS];

  logic        s2_valid_q;
  logic        s2_scale_q;
  logic [63:0] s2_prod_q;
  logic [31:0] s2_lo_q;
  logic [31:0] s2_value_q;
  logic        s2_err_q;

  logic        out_valid_q;
  out_t        out_q;

  logic        out_free, s2_adv, s2_free, exec;
  comps_t      cur, nxt;
  logic [31:0] word, span, ex_value;
  logic        adv_op, load_op;

  // Result register and stage handshakes
  assign out_free = !out_valid_q || pop;
  assign s2_adv   = s2_valid_q && out_free;
  assign s2_free  = !s2_valid_q || s2_adv;
  assign exec     = q_valid_i && s2_free;
  assign q_pop_o  = exec;
  assign empty    = !out_valid_q;
  assign result_o = out_q;

  // Execute stage
  always_comb begin
    cur.c1  = c1_q[q_head_i.chan];
    cur.c2  = c2_q[q_head_i.chan];
    cur.c3  = c3_q[q_head_i.chan];
    nxt     = taus_next(cur);
    word    = nxt.c1 ^ nxt.c2 ^ nxt.c3;
    span    = q_head_i.range_high - q_head_i.range_low;
    adv_op  = q_head_i.exists && (q_head_i.op == CMD_STEP || q_head_i.op == CMD_SCALE);
    load_op = q_head_i.exists && (q_head_i.op == CMD_LOAD);
    ex_value = '0;
    unique case (q_head_i.op)
      CMD_STEP:  ex_value = q_head_i.exists ? word : '0;
      CMD_READ:  ex_value = q_head_i.err ? '0 : last_q[q_head_i.chan];
      CMD_LOAD:  ex_value = '0;
      CMD_SCALE: ex_value = '0;
      default:   ex_value = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        c1_q[i]   <= '0;
        c2_q[i]   <= '0;
        c3_q[i]   <= '0;
        last_q[i] <= '0;
      end
    end else if (exec) begin
      if (adv_op) begin
        c1_q[q_head_i.chan]   <= nxt.c1;
        c2_q[q_head_i.chan]   <= nxt.c2;
        c3_q[q_head_i.chan]   <= nxt.c3;
        last_q[q_head_i.chan] <= word;
      end else if (load_op) begin
        c1_q[q_head_i.chan] <= q_head_i.seed_first;
        c2_q[q_head_i.chan] <= q_head_i.seed_second;
        c3_q[q_head_i.chan] <= q_head_i.seed_third;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_free) begin
      s2_valid_q <= exec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      s2_scale_q <= q_head_i.exists && (q_head_i.op == CMD_SCALE);
      s2_prod_q  <= 64'(word) * 64'(span);
      s2_lo_q    <= q_head_i.range_low;
      s2_value_q <= ex_value;
      s2_err_q   <= q_head_i.err;
    end
  end

  // Scale stage: floor(P / (2^32-1)) with P = a*2^32 + b is a + floor((a+b) / (2^32-1)),
  // and a+b never reaches three times the divisor.
  logic [31:0] hi_w, lo_w, quot, scaled;
  logic [32:0] tsum;
  logic        ge1, ge2;

  always_comb begin
    hi_w   = s2_prod_q[63:32];
    lo_w   = s2_prod_q[31:0];
    tsum   = {1'b0, hi_w} + {1'b0, lo_w};
    ge1    = (tsum >= {1'b0, WORD_MAX});
    ge2    = (tsum >= {WORD_MAX, 1'b0});
    quot   = hi_w + {31'd0, ge1} + {31'd0, ge2};
    scaled = quot + s2_lo_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      out_q.value <= s2_scale_q ? scaled : s2_value_q;
      out_q.error <= s2_err_q;
    end
  end

endmodule

`default_nettype wire
